// File: rtl/core/ftrm_pkg.sv
// ----------------------------------------------------------------------------
// ftrm_pkg
// Shared types, constants and register codes of the fan tachometer rpm meter.
// ----------------------------------------------------------------------------
package ftrm_pkg;

  localparam int TIME_W      = 32;
  localparam int RPM_W       = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int LOCKOUT_W   = 16;
  localparam int WINDOW_W    = 16;
  localparam int PPR_W       = 8;
  localparam int MSMIN_W     = 16;
  localparam int NUM_W       = TIME_W + MSMIN_W;
  localparam int DEN_W       = TIME_W + PPR_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(3000);
  localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = WINDOW_W'(1000);
  localparam logic [PPR_W-1:0]     PPR_RESET     = PPR_W'(2);
  localparam logic [MSMIN_W-1:0]   MS_PER_MIN    = MSMIN_W'(60000);
  localparam logic [RPM_W-1:0]     RPM_MAX       = '1;
  localparam logic [TIME_W-1:0]    COUNT_MAX     = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOCKOUT_US     = 2'd0,
    REG_WINDOW_MS      = 2'd1,
    REG_PULSES_PER_REV = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] edge_time_us;
    logic [TIME_W-1:0] read_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             fresh;
  } out_item_t;

  typedef struct packed {
    logic              is_read;
    logic [TIME_W-1:0] stamp;
  } q_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RPM_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/core/ftrm_front.sv
// ----------------------------------------------------------------------------
// ftrm_front
// Accepts input beats, classifies them as edge or read and picks the stamp.
// ----------------------------------------------------------------------------
module ftrm_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  ftrm_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output ftrm_pkg::q_item_t  push_item
);

  assign in_ready          = !q_full;
  assign push              = in_valid && !q_full;
  assign push_item.is_read = in_data.mode;
  assign push_item.stamp   = in_data.mode ? in_data.read_time_ms : in_data.edge_time_us;

endmodule

// File: rtl/core/ftrm_queue.sv
// ----------------------------------------------------------------------------
// ftrm_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module ftrm_queue #(
  parameter int DEPTH = ftrm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ftrm_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ftrm_pkg::q_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ftrm_pkg::q_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/ftrm_divider.sv
// ----------------------------------------------------------------------------
// ftrm_divider
// Restoring divider, one quotient bit a cycle, saturating to the rpm width.
// ----------------------------------------------------------------------------
module ftrm_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  ftrm_pkg::div_req_t req,
  output ftrm_pkg::div_rsp_t rsp
);

  localparam int NUM_W = ftrm_pkg::NUM_W;
  localparam int DEN_W = ftrm_pkg::DEN_W;
  localparam int RPM_W = ftrm_pkg::RPM_W;
  localparam logic [ftrm_pkg::DIV_CNT_W-1:0] LAST_STEP = ftrm_pkg::DIV_CNT_W'(NUM_W - 1);

  logic [DEN_W-1:0]              rem_r, rem_nxt;
  logic [NUM_W-1:0]              quo_r, quo_nxt;
  logic [DEN_W-1:0]              den_r;
  logic                          den_zero_r;
  logic [ftrm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [DEN_W:0]                shifted;
  logic                          fits;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    fits    = (shifted >= {1'b0, den_r});
    rem_nxt = fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      cnt_r      <= '0;
      rem_r      <= '0;
      quo_r      <= '0;
      den_r      <= '0;
      den_zero_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r     <= 1'b1;
        cnt_r      <= '0;
        rem_r      <= '0;
        quo_r      <= req.num;
        den_r      <= req.den;
        den_zero_r <= (req.den == '0);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = (den_zero_r || (quo_r[NUM_W-1:RPM_W] != '0)) ?
                    ftrm_pkg::RPM_MAX : quo_r[RPM_W-1:0];

endmodule

// File: rtl/core/ftrm_back.sv
// ----------------------------------------------------------------------------
// ftrm_back
// Carries out queued edges and reads, holds the meter state and the result.
// ----------------------------------------------------------------------------
module ftrm_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ftrm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                head_valid,
  input  ftrm_pkg::q_item_t                   head_item,
  output logic                                pop,
  output ftrm_pkg::div_req_t                  div_req,
  input  ftrm_pkg::div_rsp_t                  div_rsp,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ftrm_pkg::out_item_t                 out_data
);

  localparam int TIME_W = ftrm_pkg::TIME_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_LOAD, ST_DIV, ST_RES
  } state_t;

  state_t                         state_r;
  logic [ftrm_pkg::LOCKOUT_W-1:0] lockout_r;
  logic [ftrm_pkg::WINDOW_W-1:0]  window_r;
  logic [ftrm_pkg::PPR_W-1:0]     ppr_r;
  logic [TIME_W-1:0]              last_edge_r, pulse_total_r, last_measure_r, cached_rpm_r;
  logic [TIME_W-1:0]              pulses_r, dt_r;
  logic [ftrm_pkg::NUM_W-1:0]     num_r;
  logic [ftrm_pkg::DEN_W-1:0]     den_r;
  logic [ftrm_pkg::RPM_W-1:0]     res_rpm_r;
  logic                           res_fresh_r;
  logic                           out_valid_r;
  ftrm_pkg::out_item_t            out_data_r;
  logic [TIME_W-1:0]              dt_nxt;

  assign pop    = (state_r == ST_IDLE) && head_valid;
  assign dt_nxt = head_item.is_read ? head_item.stamp - last_measure_r
                                    : head_item.stamp - last_edge_r;

  assign div_req.start = (state_r == ST_LOAD);
  assign div_req.num   = num_r;
  assign div_req.den   = den_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= ftrm_pkg::LOCKOUT_RESET;
      window_r  <= ftrm_pkg::WINDOW_RESET;
      ppr_r     <= ftrm_pkg::PPR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ftrm_pkg::REG_LOCKOUT_US:     lockout_r <= cfg_wdata;
        ftrm_pkg::REG_WINDOW_MS:      window_r  <= cfg_wdata;
        ftrm_pkg::REG_PULSES_PER_REV: ppr_r     <= cfg_wdata[ftrm_pkg::PPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      last_edge_r    <= '0;
      pulse_total_r  <= '0;
      last_measure_r <= '0;
      cached_rpm_r   <= '0;
      pulses_r       <= '0;
      dt_r           <= '0;
      num_r          <= '0;
      den_r          <= '0;
      res_rpm_r      <= '0;
      res_fresh_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      out_data_r     <= '0;
    end else begin
      if (out_ready && (state_r != ST_RES)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head_valid) begin
            if (!head_item.is_read) begin
              if (dt_nxt >= TIME_W'(lockout_r)) begin
                if (pulse_total_r != ftrm_pkg::COUNT_MAX) begin
                  pulse_total_r <= pulse_total_r + 1'b1;
                end
                last_edge_r <= head_item.stamp;
              end
            end else if (dt_nxt < TIME_W'(window_r)) begin
              res_rpm_r   <= cached_rpm_r;
              res_fresh_r <= 1'b0;
              state_r     <= ST_RES;
            end else begin
              pulses_r       <= pulse_total_r;
              pulse_total_r  <= '0;
              last_measure_r <= head_item.stamp;
              dt_r           <= dt_nxt;
              state_r        <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          num_r   <= ftrm_pkg::NUM_W'(pulses_r) * ftrm_pkg::NUM_W'(ftrm_pkg::MS_PER_MIN);
          den_r   <= ftrm_pkg::DEN_W'(ppr_r) * ftrm_pkg::DEN_W'(dt_r);
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            cached_rpm_r <= div_rsp.quo;
            res_rpm_r    <= div_rsp.quo;
            res_fresh_r  <= 1'b1;
            state_r      <= ST_RES;
          end
        end
        ST_RES: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_data_r.rpm   <= res_rpm_r;
            out_data_r.fresh <= res_fresh_r;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/fan_tach_rpm_meter.sv
// ----------------------------------------------------------------------------
// fan_tach_rpm_meter
// Fan speed meter: counts debounced tach edges and answers rpm read requests.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | in_data   (mode, edge/read time)
//   out     | output    | out_valid / out_ready | out_data  (rpm, fresh)
//   cfg     | input     | cfg_we                | cfg_addr, cfg_wdata
//
// an edge beat is carried out by the back end in its idle state; a cached read
// goes from the idle state straight to the result state; a fresh read passes through
// a multiply state, a load state and the 48-step restoring divider before the result state.
// reset is synchronous, with no clearing pass.
// the input queue keeps taking beats while the back end divides or waits on
// out_ready; in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module fan_tach_rpm_meter #(
  parameter int QUEUE_DEPTH = ftrm_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ftrm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ftrm_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ftrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic               q_full, push, pop, head_valid;
  ftrm_pkg::q_item_t  push_item, head_item;
  ftrm_pkg::div_req_t div_req;
  ftrm_pkg::div_rsp_t div_rsp;

  ftrm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ftrm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ftrm_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ftrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: rtl/core/ftrm_checker.sv
// ----------------------------------------------------------------------------
// ftrm_checker
// Port-level checks of the fan tachometer rpm meter, bound to the top level.
// ----------------------------------------------------------------------------
module ftrm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ftrm_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a beat pending");

  // the queue only fills by taking a beat
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without an input beat");

endmodule

bind fan_tach_rpm_meter ftrm_checker u_ftrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fan tachometer rpm meter. Tach edge and rpm read
// beats are queued per register setting and driven through the valid/ready
// input with random gaps. The sink stalls at random, and every result beat is
// compared field by field with a local model of the pulse counter, the
// lockout, the window cache and the saturating divide.
// ----------------------------------------------------------------------------
module tb;

  localparam int TIME_W     = ftrm_pkg::TIME_W;
  localparam int RPM_W      = ftrm_pkg::RPM_W;
  localparam int CFG_ADDR_W = ftrm_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = ftrm_pkg::CFG_DATA_W;
  localparam int LOCKOUT_W  = ftrm_pkg::LOCKOUT_W;
  localparam int WINDOW_W   = ftrm_pkg::WINDOW_W;
  localparam int PPR_W      = ftrm_pkg::PPR_W;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = CFG_ADDR_W'(3);

  typedef struct {
    ftrm_pkg::in_item_t beat;
    bit                 hold;
  } pending_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  ftrm_pkg::in_item_t    in_data;
  logic                  out_valid;
  logic                  out_ready;
  ftrm_pkg::out_item_t   out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fan_tach_rpm_meter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // register mirror and meter state
  logic [LOCKOUT_W-1:0] lockout_cfg;
  logic [WINDOW_W-1:0]  window_cfg;
  logic [PPR_W-1:0]     ppr_cfg;
  logic [TIME_W-1:0]    tach_last_edge;
  logic [TIME_W-1:0]    tach_pulses;
  logic [TIME_W-1:0]    meas_last_ms;
  logic [RPM_W-1:0]     meas_rpm;

  pending_beat_t       pending_beats[$];
  ftrm_pkg::out_item_t rpm_expected[$];

  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned src_gap;
  int unsigned sink_stall;
  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned fresh_seen;
  int unsigned cfg_writes;
  logic [TIME_W-1:0] cur_us;
  logic [TIME_W-1:0] cur_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("fan_tach_rpm_meter verification failed");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 48);
  endfunction

  function automatic void predict_beat(input ftrm_pkg::in_item_t b);
    logic [TIME_W-1:0]   dt;
    logic [63:0]         num;
    logic [63:0]         den;
    logic [63:0]         quo;
    ftrm_pkg::out_item_t res;
    if (b.mode == MODE_EDGE) begin
      dt = b.edge_time_us - tach_last_edge;
      if (dt >= TIME_W'(lockout_cfg)) begin
        if (tach_pulses != ftrm_pkg::COUNT_MAX) tach_pulses = tach_pulses + 1;
        tach_last_edge = b.edge_time_us;
      end
    end else begin
      dt = b.read_time_ms - meas_last_ms;
      if (dt < TIME_W'(window_cfg)) begin
        res.rpm   = meas_rpm;
        res.fresh = 1'b0;
      end else begin
        num = 64'(tach_pulses) * 64'(60000);
        den = 64'(ppr_cfg) * 64'(dt);
        if (den == 0) quo = 64'(ftrm_pkg::RPM_MAX);
        else quo = num / den;
        if (quo > 64'(ftrm_pkg::RPM_MAX)) quo = 64'(ftrm_pkg::RPM_MAX);
        tach_pulses  = '0;
        meas_rpm     = quo[RPM_W-1:0];
        meas_last_ms = b.read_time_ms;
        res.rpm      = meas_rpm;
        res.fresh    = 1'b1;
      end
      rpm_expected.push_back(res);
    end
  endfunction

  // beat driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      src_gap  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_beat(in_data);
        beats_sent++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].hold && rpm_expected.size() != 0)) begin
          in_data  <= pending_beats[0].beat;
          in_valid <= 1'b1;
          src_gap  <= src_idle_en ? gap_len() : 0;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    ftrm_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rpm_expected.size() == 0) begin
          $error("result beat with nothing expected: rpm %0d fresh %0b",
                 out_data.rpm, out_data.fresh);
          fail_count++;
        end else begin
          want = rpm_expected.pop_front();
          results_seen++;
          if (want.fresh) fresh_seen++;
          if (out_data.rpm !== want.rpm) begin
            $error("rpm mismatch: expected %0d, actual %0d", want.rpm, out_data.rpm);
            fail_count++;
          end
          if (out_data.fresh !== want.fresh) begin
            $error("fresh mismatch: expected %0b, actual %0b", want.fresh, out_data.fresh);
            fail_count++;
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 3) == 0) sink_stall <= gap_len();
      end
    end
  end

  task automatic push_edge(input logic [TIME_W-1:0] t, input bit hold = 1'b0);
    pending_beat_t p;
    p.beat.mode         = MODE_EDGE;
    p.beat.edge_time_us = t;
    p.beat.read_time_ms = $urandom();
    p.hold              = hold;
    pending_beats.push_back(p);
    cur_us = t;
  endtask

  task automatic push_read(input logic [TIME_W-1:0] t, input bit hold = 1'b0);
    pending_beat_t p;
    p.beat.mode         = MODE_READ;
    p.beat.edge_time_us = $urandom();
    p.beat.read_time_ms = t;
    p.hold              = hold;
    pending_beats.push_back(p);
    cur_ms = t;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ftrm_pkg::REG_LOCKOUT_US:     lockout_cfg = val[LOCKOUT_W-1:0];
      ftrm_pkg::REG_WINDOW_MS:      window_cfg  = val[WINDOW_W-1:0];
      ftrm_pkg::REG_PULSES_PER_REV: ppr_cfg     = val[PPR_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || rpm_expected.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned n);
    logic [TIME_W-1:0] step;
    bit hold;
    repeat (n) begin
      hold = ($urandom_range(0, 49) == 0);
      if ($urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: step = lockout_cfg + $urandom_range(0, 64) - 32;
          5, 6, 7:       step = $urandom_range(0, 4 * lockout_cfg + 100);
          8:             step = $urandom_range(0, lockout_cfg);
          default:       step = $urandom();
        endcase
        push_edge(cur_us + step, hold);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: step = window_cfg + $urandom_range(0, 16) - 8;
          4, 5, 6:    step = $urandom_range(0, window_cfg);
          7, 8:       step = $urandom_range(0, 3 * window_cfg + 10);
          default:    step = $urandom();
        endcase
        push_read(cur_ms + step, hold);
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    fail_count   = 0;
    beats_sent   = 0;
    results_seen = 0;
    fresh_seen   = 0;
    cfg_writes   = 0;
    cur_us       = '0;
    cur_ms       = '0;
    lockout_cfg    = ftrm_pkg::LOCKOUT_RESET;
    window_cfg     = ftrm_pkg::WINDOW_RESET;
    ppr_cfg        = ftrm_pkg::PPR_RESET;
    tach_last_edge = '0;
    tach_pulses    = '0;
    meas_last_ms   = '0;
    meas_rpm       = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lockout boundary, wrapping differences, cached and fresh reads
    push_edge(32'd0);
    push_edge(32'd2999);
    push_edge(32'd3000);
    push_edge(32'd3001);
    push_edge(32'd6000);
    push_edge(32'hFFFF_FFFF);
    push_edge(32'd2999);
    push_read(32'd0);
    push_read(32'd999);
    push_read(32'd1000);
    push_read(32'd1500, 1'b1);
    push_read(32'hFFFF_FFFF);
    push_edge(32'd9000);
    push_edge(32'd12000);
    push_read(32'd999);
    push_read(32'd1998);
    push_read(32'd1999);
    wait_drained();

    random_phase(150);

    write_reg(ftrm_pkg::REG_LOCKOUT_US, 16'd0);
    write_reg(ftrm_pkg::REG_WINDOW_MS, 16'd1);
    write_reg(ftrm_pkg::REG_PULSES_PER_REV, 16'd1);
    random_phase(150);

    write_reg(ftrm_pkg::REG_LOCKOUT_US, 16'hFFFF);
    write_reg(ftrm_pkg::REG_WINDOW_MS, 16'hFFFF);
    write_reg(ftrm_pkg::REG_PULSES_PER_REV, {8'($urandom()), 8'hFF});
    random_phase(150);

    // zero divisor and a write past the register list
    write_reg(ftrm_pkg::REG_WINDOW_MS, 16'd0);
    write_reg(ftrm_pkg::REG_PULSES_PER_REV, 16'hFF00);
    write_reg(REG_SPARE, 16'($urandom()));
    push_read(cur_ms);
    push_edge(cur_us + 32'd70000);
    push_read(cur_ms);
    push_read(cur_ms + 32'd5);
    random_phase(90);
    write_reg(ftrm_pkg::REG_PULSES_PER_REV, 16'd1);
    push_edge(cur_us + 32'd70000);
    push_read(cur_ms);
    push_read(cur_ms + 32'd1);
    wait_drained();

    // mid-range setting with a stretch of no idling on either side
    write_reg(ftrm_pkg::REG_LOCKOUT_US, 16'($urandom_range(200, 5000)));
    write_reg(ftrm_pkg::REG_WINDOW_MS, 16'($urandom_range(50, 2000)));
    write_reg(ftrm_pkg::REG_PULSES_PER_REV, 16'($urandom_range(1, 8)));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    random_phase(75);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    random_phase(75);

    // tight window with a burst of back-to-back edges
    write_reg(ftrm_pkg::REG_LOCKOUT_US, 16'd0);
    write_reg(ftrm_pkg::REG_WINDOW_MS, 16'd1);
    write_reg(ftrm_pkg::REG_PULSES_PER_REV, 16'd1);
    push_read(cur_ms + 32'd10);
    src_idle_en = 1'b0;
    repeat (20) push_edge($urandom());
    push_read(cur_ms + 32'd1);
    push_read(cur_ms);
    wait_drained();
    src_idle_en = 1'b1;

    $display("sent %0d beats over %0d register writes; checked %0d rpm results",
             beats_sent, cfg_writes, results_seen);
    $display("%0d fresh measurements, %0d cached answers", fresh_seen,
             results_seen - fresh_seen);
    if (fail_count == 0) begin
      $display("fan_tach_rpm_meter verification clean");
    end else begin
      $display("fan_tach_rpm_meter verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ftrm_pkg.sv
rtl/core/ftrm_front.sv
rtl/core/ftrm_queue.sv
rtl/core/ftrm_divider.sv
rtl/core/ftrm_back.sv
rtl/core/fan_tach_rpm_meter.sv
rtl/core/ftrm_checker.sv
sim/tb.sv
